[rtl/core/ste_pkg.sv]
// ----------------------------------------------------------------------------
// ste_pkg
// Shared types, codes and the single-qubit Clifford table of the tableau
// engine.
// ----------------------------------------------------------------------------
package ste_pkg;

  localparam int unsigned MaxQubits = 64;
  localparam int unsigned QubitW    = 6;
  localparam int unsigned CfgW      = 7;
  localparam int unsigned ColW      = 4 * MaxQubits;

  // action codes
  localparam logic [4:0] ActClear   = 5'd0;
  localparam logic [4:0] ActGateLo  = 5'd1;
  localparam logic [4:0] ActGateHi  = 5'd24;
  localparam logic [4:0] ActCnot    = 5'd25;
  localparam logic [4:0] ActSwap    = 5'd26;
  localparam logic [4:0] ActMeasure = 5'd27;

  // transform codes of a gate's column rewrite
  localparam logic [2:0] XfNone     = 3'd0;
  localparam logic [2:0] XfSwap     = 3'd1;
  localparam logic [2:0] XfZxorX    = 3'd2;
  localparam logic [2:0] XfXxorZ    = 3'd3;
  localparam logic [2:0] XfSwapXxor = 3'd4;
  localparam logic [2:0] XfSwapZxor = 3'd5;

  // phase term selects
  localparam logic [1:0] IselNone = 2'd0;
  localparam logic [1:0] IselX    = 2'd1;
  localparam logic [1:0] IselZ    = 2'd2;

  typedef struct packed {
    logic [4:0] mterms;  // 1 x&z, 2 x, 4 z, 8 x&~z, 16 z&~x
    logic [1:0] isel;
    logic [2:0] xf;
  } gate_t;

  localparam gate_t GateTab [24] = '{
    '{5'd1,  2'd0, 3'd1}, '{5'd4,  2'd0, 3'd0}, '{5'd2,  2'd0, 3'd0},
    '{5'd6,  2'd0, 3'd0}, '{5'd0,  2'd1, 3'd2}, '{5'd8,  2'd0, 3'd1},
    '{5'd16, 2'd0, 3'd1}, '{5'd2,  2'd1, 3'd2}, '{5'd4,  2'd2, 3'd3},
    '{5'd0,  2'd2, 3'd3}, '{5'd18, 2'd0, 3'd1}, '{5'd4,  2'd1, 3'd2},
    '{5'd24, 2'd1, 3'd2}, '{5'd2,  2'd2, 3'd3}, '{5'd24, 2'd2, 3'd3},
    '{5'd1,  2'd1, 3'd4}, '{5'd8,  2'd2, 3'd5}, '{5'd16, 2'd1, 3'd4},
    '{5'd16, 2'd2, 3'd5}, '{5'd1,  2'd2, 3'd5}, '{5'd18, 2'd1, 3'd4},
    '{5'd18, 2'd2, 3'd5}, '{5'd8,  2'd1, 3'd4}, '{5'd0,  2'd0, 3'd0}
  };

  // exclusive prefix xor, log-step
  function automatic logic [MaxQubits-1:0] prefx(input logic [MaxQubits-1:0] u);
    logic [MaxQubits-1:0] p;
    p = u << 1;
    for (int s = 1; s < MaxQubits; s = s * 2) begin
      p = p ^ (p << s);
    end
    return p;
  endfunction

  // parity of w over generators where an odd count of u lies below
  function automatic logic pairpar(input logic [MaxQubits-1:0] u,
                                   input logic [MaxQubits-1:0] w);
    return ^(w & prefx(u));
  endfunction

endpackage

[rtl/core/stabilizer_tableau_engine_top.sv]
// ----------------------------------------------------------------------------
// stabilizer_tableau_engine_top
// Column-stored stabilizer tableau with a sequencer over one column memory.
// ----------------------------------------------------------------------------
// Steps: a gate rewrites its column; cnot/swap write column a, then b; clear writes
//   every column; measure scans the columns in use, then fixes column a when random.
// Throughput: one item at a time, busy high until it completes; at most one column written per cycle.
// Results are strobed for one cycle on result_valid_o; the receiver cannot stall.
// Reset runs a clearing pass over every column of the column memory, busy meanwhile.
module stabilizer_tableau_engine_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [4:0]                  action_i,
  input  logic [ste_pkg::QubitW-1:0]  qubit_a_i,
  input  logic [ste_pkg::QubitW-1:0]  qubit_b_i,
  input  logic                        forced_outcome_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ste_pkg::CfgW-1:0]    qubits_in_use_i,
  output logic                        result_valid_o,
  output logic                        outcome_o,
  output logic                        was_random_o
);

  localparam int unsigned N = ste_pkg::MaxQubits;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SClr   = 4'd1;
  localparam logic [3:0] SExec  = 4'd2;
  localparam logic [3:0] SWr2   = 4'd3;
  localparam logic [3:0] SScan  = 4'd4;
  localparam logic [3:0] SFixRd = 4'd5;
  localparam logic [3:0] SFix   = 4'd6;

  logic [3:0] state_q, state_d;
  logic [6:0] cnt_q, cnt_d;
  logic [4:0] act_q, act_d;
  logic [ste_pkg::QubitW-1:0] qa_q, qa_d, qb_q, qb_d, r_q, r_d, paddr_q, paddr_d;
  logic force_q, force_d, rnd_q, rnd_d, hm_q, hm_d, pend_q, pend_d;
  logic [N-1:0] amask_q, amask_d, dmask_q, dmask_d;
  logic [N-1:0] minus_q, minus_d, imag_q, imag_d;
  logic [ste_pkg::CfgW-1:0] cfg_q;
  logic res_q, res_d, out_q, out_d, wr_q, wr_d;

  logic [ste_pkg::ColW-1:0] mem [N];
  logic [ste_pkg::ColW-1:0] rda_q, rdb_q, wd;
  logic we, rea, reb;
  logic [ste_pkg::QubitW-1:0] wa, raa, rab;

  logic [6:0] nq;
  logic accept;

  assign nq = (cfg_q > 7'(N)) ? 7'(N) : cfg_q;
  assign accept = start && (state_q == SIdle);
  assign busy = (state_q != SIdle);
  assign cfg_ready_o = 1'b1;
  assign result_valid_o = res_q;
  assign outcome_o = out_q;
  assign was_random_o = wr_q;

  // column memory: {dz, dx, sz, sx}
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (rea) rda_q <= mem[raa];
    if (reb) rdb_q <= mem[rab];
  end

  always_comb begin
    logic [N-1:0] sx, sz, dx, dz, bx, bz, ex, ez, t, ia, oh, v;
    logic [N-1:0] nsx, nsz, ndx, ndz;
    logic rx, rz, found, ci;
    ste_pkg::gate_t g;

    state_d = state_q; cnt_d = cnt_q; act_d = act_q; qa_d = qa_q; qb_d = qb_q;
    r_d = r_q; paddr_d = paddr_q; force_d = force_q; rnd_d = rnd_q; hm_d = hm_q;
    pend_d = 1'b0; amask_d = amask_q; dmask_d = dmask_q;
    minus_d = minus_q; imag_d = imag_q;
    res_d = 1'b0; out_d = out_q; wr_d = wr_q;
    we = 1'b0; wa = qa_q; wd = rda_q;
    rea = 1'b0; reb = 1'b0; raa = qa_q; rab = qb_q;

    sx = rda_q[N-1:0];     sz = rda_q[2*N-1:N];
    dx = rda_q[3*N-1:2*N]; dz = rda_q[4*N-1:3*N];
    bx = rdb_q[N-1:0];     bz = rdb_q[2*N-1:N];
    ex = rdb_q[3*N-1:2*N]; ez = rdb_q[4*N-1:3*N];
    oh = '0; oh[r_q] = 1'b1;
    t = '0; ia = '0; nsx = sx; nsz = sz; ndx = dx; ndz = dz;
    rx = 1'b0; rz = 1'b0; found = 1'b0; ci = 1'b0; v = '0;
    g = ste_pkg::GateTab[0];

    case (state_q)
      SIdle: begin
        if (start) begin
          act_d = action_i; qa_d = qubit_a_i; qb_d = qubit_b_i;
          force_d = forced_outcome_i;
          rea = 1'b1; reb = 1'b1; raa = qubit_a_i; rab = qubit_b_i;
          if (action_i == ste_pkg::ActClear) begin
            cnt_d = '0; state_d = SClr;
            minus_d = '0; imag_d = '0;
          end else if (action_i == ste_pkg::ActCnot) begin
            if (qubit_a_i != qubit_b_i) state_d = SExec;
          end else if (action_i <= ste_pkg::ActMeasure) begin
            state_d = SExec;
          end
        end
      end
      SClr: begin
        we = 1'b1; wa = cnt_q[5:0];
        wd = '0;
        if (cnt_q < nq) begin
          wd[N + 32'(cnt_q[5:0])] = 1'b1;
          wd[2*N + 32'(cnt_q[5:0])] = 1'b1;
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[5:0] == 6'(N-1)) state_d = SIdle;
      end
      SExec: begin
        if (act_q == ste_pkg::ActCnot) begin
          we = 1'b1; wa = qa_q;
          wd = {dz, dx ^ ex, sz, sx ^ bx};
          state_d = SWr2;
        end else if (act_q == ste_pkg::ActSwap) begin
          we = 1'b1; wa = qa_q; wd = rdb_q;
          state_d = SWr2;
        end else if (act_q == ste_pkg::ActMeasure) begin
          for (int i = N - 1; i >= 0; i--) begin
            if (sx[i]) begin
              r_d = ste_pkg::QubitW'(i); found = 1'b1;
            end
          end
          oh = '0; oh[r_d] = 1'b1;
          cnt_d = '0; hm_d = 1'b0; rnd_d = found;
          amask_d = sx & ~oh; dmask_d = dx & ~oh;
          if (found) begin
            // replace generator r: fold its sign into the others first
            if (minus_q[r_d]) minus_d = minus_d ^ amask_d;
            if (imag_q[r_d]) begin
              imag_d[r_d] = 1'b0;
              minus_d = minus_d ^ (imag_d & amask_d);
              imag_d = imag_d ^ amask_d;
            end
          end else begin
            dmask_d = dx;
          end
          state_d = SScan;
        end else begin
          g = ste_pkg::GateTab[act_q - ste_pkg::ActGateLo];
          if (g.mterms[0]) t = t ^ (sx & sz);
          if (g.mterms[1]) t = t ^ sx;
          if (g.mterms[2]) t = t ^ sz;
          if (g.mterms[3]) t = t ^ (sx & ~sz);
          if (g.mterms[4]) t = t ^ (sz & ~sx);
          if (g.isel == ste_pkg::IselX) ia = sx;
          else if (g.isel == ste_pkg::IselZ) ia = sz;
          minus_d = minus_q ^ t ^ (imag_q & ia);
          imag_d = imag_q ^ ia;
          case (g.xf)
            ste_pkg::XfSwap:     begin nsx = sz; nsz = sx; ndx = dz; ndz = dx; end
            ste_pkg::XfZxorX:    begin nsz = sx ^ sz; ndz = dx ^ dz; end
            ste_pkg::XfXxorZ:    begin nsx = sx ^ sz; ndx = dx ^ dz; end
            ste_pkg::XfSwapXxor: begin
              nsx = sx ^ sz; nsz = sx; ndx = dx ^ dz; ndz = dx;
            end
            ste_pkg::XfSwapZxor: begin
              nsx = sz; nsz = sx ^ sz; ndx = dz; ndz = dx ^ dz;
            end
            default: ;
          endcase
          we = 1'b1; wa = qa_q; wd = {ndz, ndx, nsz, nsx};
          state_d = SIdle;
        end
      end
      SWr2: begin
        we = 1'b1; wa = qb_q;
        if (act_q == ste_pkg::ActCnot) wd = {ez ^ dz, ex, bz ^ sz, bx};
        else wd = rda_q;
        state_d = SIdle;
      end
      SScan: begin
        if (cnt_q < nq) begin
          rea = 1'b1; raa = cnt_q[5:0];
          pend_d = 1'b1; paddr_d = cnt_q[5:0];
          cnt_d = cnt_q + 7'd1;
        end
        if (pend_q) begin
          if (!rnd_q) begin
            hm_d = hm_q ^ ste_pkg::pairpar(dmask_q & sx, dmask_q & sz);
          end else begin
            rx = sx[r_q]; rz = sz[r_q];
            if (rz) minus_d = minus_q ^ (sx & amask_q);
            nsx = rx ? ((sx ^ amask_q) & ~oh) : sx;
            nsz = rz ? ((sz ^ amask_q) & ~oh) : sz;
            ndx = rx ? ((dx | oh) ^ dmask_q) : (dx & ~oh);
            ndz = rz ? ((dz | oh) ^ dmask_q) : (dz & ~oh);
            we = 1'b1; wa = paddr_q; wd = {ndz, ndx, nsz, nsx};
          end
        end
        if (!(cnt_q < nq) && !pend_q) begin
          if (rnd_q) begin
            rea = 1'b1; raa = qa_q;
            state_d = SFixRd;
          end else begin
            v = dmask_q & imag_q;
            ci = (^v) | ste_pkg::pairpar(v, v);
            out_d = hm_q ^ (^(dmask_q & minus_q)) ^ ci;
            wr_d = 1'b0; res_d = 1'b1;
            state_d = SIdle;
          end
        end
      end
      SFixRd: state_d = SFix;
      SFix: begin
        nsz = sz | oh;
        we = 1'b1; wa = qa_q; wd = {dz, dx, nsz, sx};
        minus_d[r_q] = force_q;
        out_d = force_q; wr_d = 1'b1; res_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      res_q   <= 1'b0;
      minus_q <= '0;
      imag_q  <= '0;
      cfg_q   <= 7'd64;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      res_q   <= res_d;
      minus_q <= minus_d;
      imag_q  <= imag_d;
      if (cfg_valid_i) cfg_q <= qubits_in_use_i;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; qa_q <= qa_d; qb_q <= qb_d; r_q <= r_d; paddr_q <= paddr_d;
    force_q <= force_d; rnd_q <= rnd_d; hm_q <= hm_d;
    amask_q <= amask_d; dmask_q <= dmask_d;
    out_q <= out_d; wr_q <= wr_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) result_valid_o |-> !busy)
    else $error("result strobed while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (action_i == ste_pkg::ActMeasure) |=> busy)
    else $error("measure accepted but engine not busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q |-> state_q == SScan)
    else $error("scan word pending outside scan");
  assert property (@(posedge clk_i) disable iff (!rst_ni) (state_q == SIdle) |-> !we)
    else $error("column write while idle");

endmodule
